>>> design/zls_pkg.sv
// Package for the zone latency statistics block.
// Holds the sequencer states, the entry layout, divider interface structs and constants.
// No dependencies; used by zls_div and zone_latency_statistics.
package zls_pkg;

    // Nanoseconds per millisecond tick scale (fits in 20 bits)
    localparam int          SCALE_W  = 20;
    localparam logic [19:0] NS_SCALE = 20'd1000000;

    // Field widths
    localparam int ZONE_W = 6;
    localparam int TS_W   = 64;
    localparam int STAT_W = 64;
    localparam int KHZ_W  = 32;

    // Configuration register indexes
    localparam logic CFG_ENABLE  = 1'b0;
    localparam logic CFG_TSC_KHZ = 1'b1;

    // One zone entry as it sits in the table
    typedef struct packed {
        logic [STAT_W-1:0] most;
        logic [STAT_W-1:0] least;
        logic [STAT_W-1:0] sum;
        logic [STAT_W-1:0] count;
    } entry_t;

    // Divider control and status
    typedef struct packed {
        logic              start;
        logic [TS_W-1:0]   dividend;
        logic [KHZ_W-1:0]  divisor;
    } div_ctrl_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [TS_W-1:0]   quotient;
    } div_stat_t;

    // Item sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SCALE,
        ST_DIV,
        ST_READ,
        ST_UPDATE,
        ST_EMIT
    } zls_state_t;

endpackage

>>> design/zls_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
// Depends on zls_pkg for the control and status structs.
module zls_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  zls_pkg::div_ctrl_t  ctrl,
    output zls_pkg::div_stat_t  stat
);

    localparam int STEPS = zls_pkg::TS_W;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

    logic [zls_pkg::TS_W-1:0]  quot_reg;
    logic [zls_pkg::KHZ_W-1:0] rem_reg;
    logic [zls_pkg::KHZ_W-1:0] dvsr_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [zls_pkg::KHZ_W:0]   trial;
    logic                      fits;
    logic [zls_pkg::KHZ_W:0]   diff;

    // One trial subtraction per cycle
    always_comb begin
        trial = {rem_reg, quot_reg[zls_pkg::TS_W-1]};
        diff  = trial - {1'b0, dvsr_reg};
        fits  = (trial >= {1'b0, dvsr_reg});
    end

    // Control: step counter and done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out the top, quotient bits shift in the bottom
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            quot_reg <= ctrl.dividend;
            rem_reg  <= '0;
            dvsr_reg <= ctrl.divisor;
        end else if (busy_reg) begin
            quot_reg <= {quot_reg[zls_pkg::TS_W-2:0], fits};
            rem_reg  <= fits ? diff[zls_pkg::KHZ_W-1:0] : trial[zls_pkg::KHZ_W-1:0];
        end
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = quot_reg;

endmodule

>>> design/zone_latency_statistics.sv
// Top level of the zone latency statistics table.
// Depends on zls_pkg and zls_div (iterative duration divider).
//
//  channel   ports                     direction  contents
//  input     s_tvalid/s_tready/...     in         one record or clear item
//  result    m_tvalid/m_tready/...     out        duration and updated zone stats
//  config    cfg_wen/cfg_index/...     in         enable, tsc_khz writes
//
// A record item passes through capture, two 32x20 partial products, a scale add,
// 64 divider steps with the quotient pick-up, a table read, a write back and the
// output load. With tsc_khz at zero the divider is skipped. Clear and ignored
// items go straight from capture to the output load. Reset clears the valid bits
// of all entries at once, so no clearing pass is needed. A waiting result sits in
// the output register; the next item is taken meanwhile and stalls only at its end.
module zone_latency_statistics #(
    parameter int ZONE_COUNT = 12
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // zone[5:0], start_time[69:6], now_time[133:70], zeros
    input  logic         s_tuser,   // op
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [319:0] m_tdata,   // duration_ns, hit_count, sum_ns, least_ns, most_ns
    output logic         m_tuser,   // recorded
    // configuration
    input  logic         cfg_wen,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_wdata
);

    localparam int ADDR_W = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
    localparam logic [zls_pkg::ZONE_W:0] ZONE_LIMIT = 7'(ZONE_COUNT);
    localparam int PROD_W = 32 + zls_pkg::SCALE_W;

    // Configuration registers
    logic                      enable_reg;
    logic [zls_pkg::KHZ_W-1:0] khz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b1;
            khz_reg    <= '0;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                zls_pkg::CFG_ENABLE:  enable_reg <= cfg_wdata[0];
                zls_pkg::CFG_TSC_KHZ: khz_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer and datapath registers
    zls_pkg::zls_state_t       state_reg, state_next;
    logic [zls_pkg::ZONE_W-1:0] zone_reg;
    logic [zls_pkg::TS_W-1:0]  delta_reg;
    logic [PROD_W-1:0]         prod_lo_reg;
    logic [31:0]               prod_hi_reg;
    logic [zls_pkg::STAT_W-1:0] ns_reg;
    zls_pkg::entry_t           rd_reg;
    logic                      rd_valid_reg;
    zls_pkg::entry_t           res_reg;
    logic [zls_pkg::STAT_W-1:0] res_ns_reg;
    logic                      res_rec_reg;
    logic [ZONE_COUNT-1:0]     valid_reg;
    logic                      m_valid_reg;
    logic [319:0]              m_data_reg;
    logic                      m_user_reg;

    zls_pkg::entry_t           mem [ZONE_COUNT];

    logic                      accept;
    logic                      in_op;
    logic [zls_pkg::ZONE_W-1:0] in_zone;
    logic [zls_pkg::TS_W-1:0]  in_delta;
    logic                      in_take;
    logic [31:0]               mul_a;
    logic [PROD_W-1:0]         mul_p;
    logic [zls_pkg::TS_W-1:0]  scaled;
    logic [ADDR_W-1:0]         addr;
    zls_pkg::entry_t           old_e;
    zls_pkg::entry_t           new_e;
    logic                      out_free;
    zls_pkg::div_ctrl_t        div_ctrl;
    zls_pkg::div_stat_t        div_stat;

    // Input decode
    always_comb begin
        in_op    = s_tuser;
        in_zone  = s_tdata[5:0];
        in_delta = s_tdata[133:70] - s_tdata[69:6];
        in_take  = !in_op && enable_reg && ({1'b0, in_zone} < ZONE_LIMIT);
        accept   = s_tvalid && s_tready;
        out_free = !m_valid_reg || m_tready;
        addr     = zone_reg[ADDR_W-1:0];
    end

    // Shared 32x20 multiplier for the two partial products
    always_comb begin
        mul_a  = (state_reg == zls_pkg::ST_MUL_LO) ? delta_reg[31:0] : delta_reg[63:32];
        mul_p  = PROD_W'(mul_a) * PROD_W'(zls_pkg::NS_SCALE);
        scaled = zls_pkg::TS_W'(prod_lo_reg) + {prod_hi_reg, 32'd0};
    end

    // Divider start
    always_comb begin
        div_ctrl.start    = (state_reg == zls_pkg::ST_SCALE) && (khz_reg != '0);
        div_ctrl.dividend = scaled;
        div_ctrl.divisor  = khz_reg;
    end

    zls_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .stat    (div_stat)
    );

    // Entry update; an entry never written since reset or clear reads as zero
    always_comb begin
        old_e       = rd_valid_reg ? rd_reg : '0;
        new_e.count = old_e.count + 1'b1;
        new_e.sum   = old_e.sum + ns_reg;
        if (new_e.count == zls_pkg::STAT_W'(1)) begin
            new_e.least = ns_reg;
            new_e.most  = ns_reg;
        end else begin
            new_e.least = (ns_reg < old_e.least) ? ns_reg : old_e.least;
            new_e.most  = (ns_reg > old_e.most)  ? ns_reg : old_e.most;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            zls_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = in_take ? zls_pkg::ST_MUL_LO : zls_pkg::ST_EMIT;
                end
            end
            zls_pkg::ST_MUL_LO: state_next = zls_pkg::ST_MUL_HI;
            zls_pkg::ST_MUL_HI: state_next = zls_pkg::ST_SCALE;
            zls_pkg::ST_SCALE: begin
                state_next = (khz_reg != '0) ? zls_pkg::ST_DIV : zls_pkg::ST_READ;
            end
            zls_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    state_next = zls_pkg::ST_READ;
                end
            end
            zls_pkg::ST_READ:   state_next = zls_pkg::ST_UPDATE;
            zls_pkg::ST_UPDATE: state_next = zls_pkg::ST_EMIT;
            zls_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = zls_pkg::ST_IDLE;
                end
            end
            default: state_next = zls_pkg::ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= zls_pkg::ST_IDLE;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept && in_op) begin
                valid_reg <= '0;
            end else if (state_reg == zls_pkg::ST_UPDATE) begin
                valid_reg[addr] <= 1'b1;
            end
            if (state_reg == zls_pkg::ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            zls_pkg::ST_IDLE: begin
                zone_reg    <= in_zone;
                delta_reg   <= in_delta;
                res_reg     <= '0;
                res_ns_reg  <= '0;
                res_rec_reg <= 1'b0;
            end
            zls_pkg::ST_MUL_LO: prod_lo_reg <= mul_p;
            zls_pkg::ST_MUL_HI: prod_hi_reg <= mul_p[31:0];
            zls_pkg::ST_SCALE:  ns_reg      <= '0;
            zls_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    ns_reg <= div_stat.quotient;
                end
            end
            zls_pkg::ST_READ: rd_valid_reg <= valid_reg[addr];
            zls_pkg::ST_UPDATE: begin
                res_reg     <= new_e;
                res_ns_reg  <= ns_reg;
                res_rec_reg <= 1'b1;
            end
            zls_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_data_reg <= {res_reg.most, res_reg.least, res_reg.sum,
                                   res_reg.count, res_ns_reg};
                    m_user_reg <= res_rec_reg;
                end
            end
            default: ;
        endcase
    end

    // Statistics table: read in the read state, written back in the update state
    always_ff @(posedge aclk) begin
        if (state_reg == zls_pkg::ST_READ) begin
            rd_reg <= mem[addr];
        end
        if (state_reg == zls_pkg::ST_UPDATE) begin
            mem[addr] <= new_e;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
